// ===== hw/rtl/sst_pkg.sv =====
// Shared types and constants for the sparse set table.
package sst_pkg;

  localparam int unsigned CAPACITY     = 256;
  localparam int unsigned MAX_ENTITIES = 1024;
  localparam int unsigned DATA_WIDTH   = 32;

  localparam int unsigned SLOT_W = $clog2(CAPACITY);
  localparam int unsigned ENT_W  = $clog2(MAX_ENTITIES);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned MAP_W  = SLOT_W + 1;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned CAP_W  = 9;
  localparam int unsigned LIM_W  = 11;

  // opcodes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // result status
  localparam logic [2:0] STATUS_NEW      = 3'd0;
  localparam logic [2:0] STATUS_EXISTING = 3'd1;
  localparam logic [2:0] STATUS_RANGE    = 3'd2;
  localparam logic [2:0] STATUS_ABSENT   = 3'd3;
  localparam logic [2:0] STATUS_FULL     = 3'd4;

  // config register indexes
  localparam logic [1:0] CFG_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_COMP_EN  = 2'd2;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [ID_W-1:0]       entity_id;
    logic [7:0]            slot_index;
    logic [DATA_WIDTH-1:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [7:0]            dense_slot;
    logic [ID_W-1:0]       entity_out;
    logic [DATA_WIDTH-1:0] data_out;
    logic [CNT_W-1:0]      live_count;
  } out_word_t;

  typedef struct packed {
    logic [CAP_W-1:0] capacity_in_use;
    logic [LIM_W-1:0] entity_limit;
    logic             component_enable;
  } cfg_t;

  typedef struct packed {
    logic              present;
    logic [SLOT_W-1:0] slot;
  } map_ent_t;

  typedef struct packed {
    logic             we;
    logic [ENT_W-1:0] waddr;
    map_ent_t         wdata;
    logic [ENT_W-1:0] raddr;
  } map_req_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [ID_W-1:0]   wdata;
    logic [SLOT_W-1:0] raddr;
  } owner_req_t;

  typedef struct packed {
    logic                  we;
    logic [SLOT_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [SLOT_W-1:0]     raddr;
  } comp_req_t;

endpackage

// ===== hw/rtl/sst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sst_ctrl.sv =====
// Sequencer for the sparse set: map clear, add, swap-remove, lookup, slot read.
module sst_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sst_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sst_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sst_pkg::out_word_t            out_word_o,
  output sst_pkg::map_req_t             map_req_o,
  input  sst_pkg::map_ent_t             map_rdata_i,
  output sst_pkg::owner_req_t           owner_req_o,
  input  logic [sst_pkg::ID_W-1:0]      owner_rdata_i,
  output sst_pkg::comp_req_t            comp_req_o,
  input  logic [sst_pkg::DATA_WIDTH-1:0] comp_rdata_i
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_LOOK  = 3'd4;
  localparam logic [2:0] S_MOVE  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                     state_q, state_d;
  logic [sst_pkg::ENT_W-1:0]      clr_q, clr_d;
  logic [sst_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic                           out_valid_q, out_valid_d;
  sst_pkg::in_word_t              item_q, item_d;
  sst_pkg::out_word_t             res_q, res_d;
  sst_pkg::out_word_t             out_q, out_d;
  logic [sst_pkg::ID_W-1:0]       moved_q, moved_d;
  logic [sst_pkg::SLOT_W-1:0]     slot_q, slot_d;

  logic [sst_pkg::CAP_W-1:0]      eff_cap;
  logic [sst_pkg::LIM_W-1:0]      eff_lim;
  logic                           id_ok;
  logic [sst_pkg::SLOT_W-1:0]     last_slot;
  logic [sst_pkg::SLOT_W-1:0]     rd_slot;

  assign eff_cap = (cfg_i.capacity_in_use > sst_pkg::CAP_W'(sst_pkg::CAPACITY)) ?
                   sst_pkg::CAP_W'(sst_pkg::CAPACITY) : cfg_i.capacity_in_use;
  assign eff_lim = (cfg_i.entity_limit > sst_pkg::LIM_W'(sst_pkg::MAX_ENTITIES)) ?
                   sst_pkg::LIM_W'(sst_pkg::MAX_ENTITIES) : cfg_i.entity_limit;
  assign id_ok   = item_q.entity_id < sst_pkg::ID_W'(eff_lim);

  // last live slot, used as the move source on remove
  assign last_slot = (cnt_q == '0) ? '0 : sst_pkg::SLOT_W'(cnt_q - 1'b1);
  assign rd_slot   = (item_q.opcode == sst_pkg::OP_READ) ? item_q.slot_index[sst_pkg::SLOT_W-1:0]
                                                         : last_slot;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    item_d      = item_q;
    res_d       = res_q;
    out_d       = out_q;
    moved_d     = moved_q;
    slot_d      = slot_q;

    map_req_o       = '0;
    map_req_o.raddr = item_q.entity_id[sst_pkg::ENT_W-1:0];
    owner_req_o       = '0;
    owner_req_o.raddr = rd_slot;
    comp_req_o        = '0;
    comp_req_o.raddr  = rd_slot;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        map_req_o.we    = 1'b1;
        map_req_o.waddr = clr_q;
        map_req_o.wdata = '0;
        clr_d           = clr_q + 1'b1;
        if (clr_q == sst_pkg::ENT_W'(sst_pkg::MAX_ENTITIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_word_i;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        res_d            = '0;
        res_d.status     = sst_pkg::STATUS_RANGE;
        state_d          = S_DONE;
        if (item_q.opcode == sst_pkg::OP_READ) begin
          if ({1'b0, item_q.slot_index} < cnt_q) begin
            res_d.status     = sst_pkg::STATUS_EXISTING;
            res_d.dense_slot = item_q.slot_index;
            res_d.entity_out = owner_rdata_i;
            res_d.data_out   = cfg_i.component_enable ? comp_rdata_i : '0;
          end
        end else if (id_ok) begin
          if (item_q.opcode == sst_pkg::OP_ADD) begin
            if (map_rdata_i.present) begin
              res_d.status     = sst_pkg::STATUS_EXISTING;
              res_d.dense_slot = 8'(map_rdata_i.slot);
              comp_req_o.waddr = map_rdata_i.slot;
            end else if (cnt_q >= eff_cap) begin
              res_d.status = sst_pkg::STATUS_FULL;
            end else begin
              res_d.status          = sst_pkg::STATUS_NEW;
              res_d.dense_slot      = 8'(cnt_q[sst_pkg::SLOT_W-1:0]);
              owner_req_o.we        = 1'b1;
              owner_req_o.waddr     = cnt_q[sst_pkg::SLOT_W-1:0];
              owner_req_o.wdata     = item_q.entity_id;
              map_req_o.we          = 1'b1;
              map_req_o.waddr       = item_q.entity_id[sst_pkg::ENT_W-1:0];
              map_req_o.wdata.present = 1'b1;
              map_req_o.wdata.slot  = cnt_q[sst_pkg::SLOT_W-1:0];
              comp_req_o.waddr      = cnt_q[sst_pkg::SLOT_W-1:0];
              cnt_d                 = cnt_q + 1'b1;
            end
            if (res_d.status != sst_pkg::STATUS_FULL && cfg_i.component_enable) begin
              comp_req_o.we    = 1'b1;
              comp_req_o.wdata = item_q.data_in;
              res_d.data_out   = item_q.data_in;
            end
          end else if (!map_rdata_i.present) begin
            res_d.status = sst_pkg::STATUS_ABSENT;
          end else if (item_q.opcode == sst_pkg::OP_REMOVE) begin
            res_d.status     = sst_pkg::STATUS_EXISTING;
            res_d.dense_slot = 8'(map_rdata_i.slot);
            map_req_o.we     = 1'b1;
            map_req_o.waddr  = item_q.entity_id[sst_pkg::ENT_W-1:0];
            map_req_o.wdata  = '0;
            if (cnt_q != '0) begin
              cnt_d = cnt_q - 1'b1;
            end
            if (map_rdata_i.slot != last_slot) begin
              // last entry fills the hole; its map entry is fixed next cycle
              owner_req_o.we    = 1'b1;
              owner_req_o.waddr = map_rdata_i.slot;
              owner_req_o.wdata = owner_rdata_i;
              comp_req_o.we     = cfg_i.component_enable;
              comp_req_o.waddr  = map_rdata_i.slot;
              comp_req_o.wdata  = comp_rdata_i;
              moved_d           = owner_rdata_i;
              slot_d            = map_rdata_i.slot;
              state_d           = S_MOVE;
            end
          end else begin
            res_d.status     = sst_pkg::STATUS_EXISTING;
            res_d.dense_slot = 8'(map_rdata_i.slot);
            comp_req_o.raddr = map_rdata_i.slot;
            state_d          = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        res_d.data_out = cfg_i.component_enable ? comp_rdata_i : '0;
        state_d        = S_DONE;
      end
      S_MOVE: begin
        if (moved_q < sst_pkg::ID_W'(sst_pkg::MAX_ENTITIES)) begin
          map_req_o.we            = 1'b1;
          map_req_o.waddr         = moved_q[sst_pkg::ENT_W-1:0];
          map_req_o.wdata.present = 1'b1;
          map_req_o.wdata.slot    = slot_q;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d            = res_q;
          out_d.live_count = cnt_q;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    res_q   <= res_d;
    out_q   <= out_d;
    moved_q <= moved_d;
    slot_q  <= slot_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== hw/rtl/sparse_set_table.sv =====
// Sparse set table top level: config registers, the three RAMs and the sequencer.
//
// Sparse set of entity ids (below entity_limit, at most 1024) packed into up to 256 slots,
// with an optional 32-bit component word per slot. Opcodes: add (new or existing slot,
// data_in written as the component), remove (swap-with-last: the last live entity and its
// component move into the freed slot), lookup by id, and read of a packed slot. One word is
// handled at a time: each word goes through READ and EXEC, then DONE, before in_ready_o
// rises again; lookup hits add LOOK and removes that move an entry add MOVE before DONE.
// These steps come from the registered reads of the map, slot-owner and component RAMs (one read
// port each), and from the map's one write port (remove writes the map twice). The result sits
// in an output register, so the next word is accepted while it waits to be taken. After reset
// a clearing pass marks all 1024 map entries absent, one per cycle, so in_ready_o stays low
// until it ends; configuration writes are taken at any time through
// cfg_we_i/cfg_index_i/cfg_wdata_i (0 capacity_in_use, 1 entity_limit, 2 component_enable;
// other indexes ignored) and are meant to be written only while the block is idle.
module sparse_set_table (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  sst_pkg::in_word_t       in_word_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output sst_pkg::out_word_t      out_word_o,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [sst_pkg::LIM_W-1:0] cfg_wdata_i
);

  sst_pkg::cfg_t       cfg_q, cfg_d;
  sst_pkg::map_req_t   map_req;
  sst_pkg::map_ent_t   map_rdata;
  sst_pkg::owner_req_t owner_req;
  logic [sst_pkg::ID_W-1:0]       owner_rdata;
  sst_pkg::comp_req_t  comp_req;
  logic [sst_pkg::DATA_WIDTH-1:0] comp_rdata;

  // config register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        sst_pkg::CFG_CAPACITY: cfg_d.capacity_in_use  = cfg_wdata_i[sst_pkg::CAP_W-1:0];
        sst_pkg::CFG_LIMIT:    cfg_d.entity_limit     = cfg_wdata_i;
        sst_pkg::CFG_COMP_EN:  cfg_d.component_enable = cfg_wdata_i[0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity_in_use  <= sst_pkg::CAP_W'(sst_pkg::CAPACITY);
      cfg_q.entity_limit     <= sst_pkg::LIM_W'(sst_pkg::MAX_ENTITIES);
      cfg_q.component_enable <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // entity id -> {present, slot}
  sst_ram #(
    .WIDTH (sst_pkg::MAP_W),
    .DEPTH (sst_pkg::MAX_ENTITIES)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_req.we),
    .waddr_i (map_req.waddr),
    .wdata_i (map_req.wdata),
    .raddr_i (map_req.raddr),
    .rdata_o (map_rdata)
  );

  // packed slot -> entity id
  sst_ram #(
    .WIDTH (sst_pkg::ID_W),
    .DEPTH (sst_pkg::CAPACITY)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (owner_req.we),
    .waddr_i (owner_req.waddr),
    .wdata_i (owner_req.wdata),
    .raddr_i (owner_req.raddr),
    .rdata_o (owner_rdata)
  );

  // packed slot -> component word
  sst_ram #(
    .WIDTH (sst_pkg::DATA_WIDTH),
    .DEPTH (sst_pkg::CAPACITY)
  ) u_comp_ram (
    .clk_i   (clk_i),
    .we_i    (comp_req.we),
    .waddr_i (comp_req.waddr),
    .wdata_i (comp_req.wdata),
    .raddr_i (comp_req.raddr),
    .rdata_o (comp_rdata)
  );

  sst_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_word_i     (in_word_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_word_o    (out_word_o),
    .map_req_o     (map_req),
    .map_rdata_i   (map_rdata),
    .owner_req_o   (owner_req),
    .owner_rdata_i (owner_rdata),
    .comp_req_o    (comp_req),
    .comp_rdata_i  (comp_rdata)
  );

  // one word at a time: ready drops right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("sst: accepted a second word while busy");

  // live count never exceeds the slot count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.live_count <= sst_pkg::CNT_W'(sst_pkg::CAPACITY)))
    else $error("sst: live count above capacity");

  // a fresh add always leaves at least one live entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.status == sst_pkg::STATUS_NEW)) |->
      (out_word_o.live_count != '0))
    else $error("sst: new entry reported with empty set");

endmodule

// ===== dv/sparse_set_table_tb.sv =====
// Testbench for the sparse set table: directed and random words checked against a model.
module sparse_set_table_tb;
  import sst_pkg::*;

  localparam int unsigned POOL_N = 40;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_word_t            in_word;
  logic                out_valid;
  logic                out_ready;
  out_word_t           out_word;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [LIM_W-1:0]    cfg_wdata;

  sparse_set_table dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Shadow copy of the table and its registers, updated as each word is accepted.
  bit                    map_present [MAX_ENTITIES];
  logic [SLOT_W-1:0]     map_slot    [MAX_ENTITIES];
  logic [ID_W-1:0]       slot_owner  [CAPACITY];
  logic [DATA_WIDTH-1:0] slot_comp   [CAPACITY];
  int unsigned           live_entries = 0;
  int unsigned           cap_reg      = 256;
  int unsigned           lim_reg      = 1024;
  bit                    comp_en      = 1'b1;

  out_word_t   pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  int          id_order [MAX_ENTITIES];
  int          hot_ids  [POOL_N];

  // Result of one word on the shadow table; updates the shadow state.
  function automatic out_word_t table_step(in_word_t w);
    out_word_t         r;
    int unsigned       cap_eff;
    int unsigned       lim_eff;
    int unsigned       last;
    logic [SLOT_W-1:0] s;
    r = '0;
    s = '0;
    r.status = STATUS_RANGE;
    cap_eff = (cap_reg > CAPACITY) ? CAPACITY : cap_reg;
    lim_eff = (lim_reg > MAX_ENTITIES) ? MAX_ENTITIES : lim_reg;
    if (w.opcode == OP_READ) begin
      if (w.slot_index < live_entries) begin
        r.status     = STATUS_EXISTING;
        r.dense_slot = w.slot_index;
        r.entity_out = slot_owner[w.slot_index];
        if (comp_en) r.data_out = slot_comp[w.slot_index];
      end
    end else if (w.entity_id < lim_eff) begin
      case (w.opcode)
        OP_ADD: begin
          if (map_present[w.entity_id]) begin
            r.status = STATUS_EXISTING;
            s = map_slot[w.entity_id];
          end else if (live_entries >= cap_eff) begin
            r.status = STATUS_FULL;
          end else begin
            r.status = STATUS_NEW;
            s = SLOT_W'(live_entries);
            slot_owner[s] = w.entity_id;
            map_slot[w.entity_id] = s;
            map_present[w.entity_id] = 1'b1;
            live_entries++;
          end
          if (r.status != STATUS_FULL) begin
            r.dense_slot = s;
            if (comp_en) begin
              slot_comp[s] = w.data_in;
              r.data_out = w.data_in;
            end
          end
        end
        OP_REMOVE: begin
          if (!map_present[w.entity_id]) begin
            r.status = STATUS_ABSENT;
          end else begin
            // swap-with-last: last live entity and its word fill the hole
            r.status = STATUS_EXISTING;
            s = map_slot[w.entity_id];
            r.dense_slot = s;
            last = live_entries - 1;
            if (s != last) begin
              slot_owner[s] = slot_owner[last];
              map_slot[slot_owner[last]] = s;
              if (comp_en) slot_comp[s] = slot_comp[last];
            end
            map_present[w.entity_id] = 1'b0;
            live_entries--;
          end
        end
        default: begin
          if (!map_present[w.entity_id]) begin
            r.status = STATUS_ABSENT;
          end else begin
            r.status = STATUS_EXISTING;
            r.dense_slot = map_slot[w.entity_id];
            if (comp_en) r.data_out = slot_comp[map_slot[w.entity_id]];
          end
        end
      endcase
    end
    r.live_count = CNT_W'(live_entries);
    return r;
  endfunction

  function automatic in_word_t make_word(logic [1:0] op, logic [ID_W-1:0] id,
                                         logic [7:0] idx, logic [DATA_WIDTH-1:0] data);
    in_word_t w;
    w.opcode     = op;
    w.entity_id  = id;
    w.slot_index = idx;
    w.data_in    = data;
    return w;
  endfunction

  // Mostly well-formed words on the hot id pool; a few words of pure noise.
  function automatic in_word_t random_word();
    int unsigned roll;
    logic [7:0]  idx;
    roll = $urandom_range(99);
    if (roll < 8) return make_word(2'($urandom_range(3)), 16'($urandom), 8'($urandom),
                                   $urandom);
    if (live_entries != 0 && $urandom_range(9) != 0) idx = 8'($urandom_range(live_entries - 1));
    else idx = 8'($urandom_range(255));
    roll = $urandom_range(99);
    if (roll < 40) return make_word(OP_ADD, 16'(hot_ids[$urandom_range(POOL_N - 1)]), idx,
                                    $urandom);
    if (roll < 65) return make_word(OP_REMOVE, 16'(hot_ids[$urandom_range(POOL_N - 1)]), idx,
                                    $urandom);
    if (roll < 82) return make_word(OP_LOOKUP, 16'(hot_ids[$urandom_range(POOL_N - 1)]), idx,
                                    $urandom);
    return make_word(OP_READ, 16'($urandom), idx, $urandom);
  endfunction

  // Offer one word; valid stays up across back-to-back words.
  task automatic send_word(input in_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(table_step(w));
  endtask

  // Wait until every expected word is back and the sequencer has settled.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= LIM_W'(value);
    @(posedge clk);
    case (idx)
      CFG_CAPACITY: cap_reg = value & 32'h1FF;
      CFG_LIMIT:    lim_reg = value & 32'h7FF;
      CFG_COMP_EN:  comp_en = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input int unsigned cap, input int unsigned lim, input bit en);
    drain();
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_LIMIT, lim);
    write_reg(CFG_COMP_EN, en);
  endtask

  task automatic shuffle_ids(input int n);
    int j;
    int t;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = id_order[i];
      id_order[i] = id_order[j];
      id_order[j] = t;
    end
  endtask

  // Half the pool comes from live entities so removes and lookups hit.
  task automatic pick_hot_ids();
    int unsigned lim_eff;
    lim_eff = (lim_reg > MAX_ENTITIES) ? MAX_ENTITIES : lim_reg;
    for (int i = 0; i < POOL_N; i++) begin
      if (live_entries != 0 && i % 2 == 0)
        hot_ids[i] = slot_owner[$urandom_range(live_entries - 1)];
      else
        hot_ids[i] = $urandom_range(lim_eff - 1);
    end
  endtask

  // Field extremes, every opcode, swap-remove of the first and last slots.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(make_word(OP_LOOKUP, 16'd0, 8'd0, 32'd0));            // lookup on empty table
    send_word(make_word(OP_REMOVE, 16'd5, 8'd0, 32'd0));            // remove absent
    send_word(make_word(OP_READ, 16'd0, 8'd0, 32'd0));              // read with no live slots
    send_word(make_word(OP_ADD, 16'd0, 8'd0, 32'h0000_0000));
    send_word(make_word(OP_ADD, 16'd1023, 8'd0, 32'hFFFF_FFFF));
    send_word(make_word(OP_ADD, 16'd1023, 8'd0, 32'hA5A5_5A5A));    // existing, word overwritten
    send_word(make_word(OP_ADD, 16'd1024, 8'd0, 32'h1));            // first id out of range
    send_word(make_word(OP_ADD, 16'hFFFF, 8'hFF, 32'h2));
    send_word(make_word(OP_LOOKUP, 16'd1023, 8'd0, 32'd0));
    send_word(make_word(OP_READ, 16'hFFFF, 8'd1, 32'd0));
    send_word(make_word(OP_READ, 16'd0, 8'hFF, 32'd0));             // beyond live slots
    send_word(make_word(OP_ADD, 16'd7, 8'd0, 32'h1234_5678));
    send_word(make_word(OP_REMOVE, 16'd0, 8'd0, 32'd0));            // slot 0 freed, id 7 moves in
    send_word(make_word(OP_LOOKUP, 16'd7, 8'd0, 32'd0));
    send_word(make_word(OP_READ, 16'd0, 8'd0, 32'd0));
    send_word(make_word(OP_REMOVE, 16'd7, 8'd0, 32'd0));
    send_word(make_word(OP_REMOVE, 16'd1023, 8'd0, 32'd0));         // last slot, nothing moves
    send_word(make_word(OP_REMOVE, 16'd1023, 8'd0, 32'd0));
    send_word(make_word(OP_LOOKUP, 16'hFFFF, 8'd0, 32'd0));
    send_word(make_word(OP_REMOVE, 16'd40000, 8'd0, 32'd0));
    send_word(make_word(OP_READ, 16'd0, 8'd0, 32'd0));
    drain();
  endtask

  // Fill all 256 slots (this also writes every component word once), overflow, then empty.
  task automatic test_fill_and_empty();
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    shuffle_ids(MAX_ENTITIES);
    for (int i = 0; i < CAPACITY; i++) begin
      send_word(make_word(OP_ADD, 16'(id_order[i]), 8'd0, $urandom));
    end
    send_word(make_word(OP_ADD, 16'(id_order[CAPACITY]), 8'd0, $urandom));  // full
    send_word(make_word(OP_ADD, 16'(id_order[3]), 8'd0, $urandom));
    send_word(make_word(OP_READ, 16'd0, 8'hFF, 32'd0));
    send_word(make_word(OP_LOOKUP, 16'(id_order[100]), 8'd0, 32'd0));
    shuffle_ids(CAPACITY);
    for (int i = 0; i < CAPACITY; i++) begin
      send_word(make_word(OP_REMOVE, 16'(id_order[i]), 8'd0, 32'd0));
      if ($urandom_range(7) == 0) begin
        if ($urandom_range(1) == 0)
          send_word(make_word(OP_LOOKUP, 16'(id_order[$urandom_range(CAPACITY - 1)]), 8'd0,
                              32'd0));
        else
          send_word(make_word(OP_READ, 16'd0, 8'($urandom_range(255)), 32'd0));
      end
    end
    drain();
  endtask

  // Register extremes, including limits dropped below the live contents.
  task automatic test_limits();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_config(0, 1024, 1'b1);
    send_word(make_word(OP_ADD, 16'd10, 8'd0, 32'h10));
    send_word(make_word(OP_LOOKUP, 16'd10, 8'd0, 32'd0));
    set_config(1, 1024, 1'b1);
    send_word(make_word(OP_ADD, 16'd10, 8'd0, 32'h10));
    send_word(make_word(OP_ADD, 16'd11, 8'd0, 32'h11));
    send_word(make_word(OP_ADD, 16'd10, 8'd0, 32'h1010));
    set_config(511, 1024, 1'b1);                                     // acts as 256
    send_word(make_word(OP_ADD, 16'd11, 8'd0, 32'h11));
    send_word(make_word(OP_ADD, 16'd12, 8'd0, 32'h12));
    set_config(256, 0, 1'b1);                                        // no id valid
    send_word(make_word(OP_LOOKUP, 16'd10, 8'd0, 32'd0));
    send_word(make_word(OP_ADD, 16'd0, 8'd0, 32'h1));
    send_word(make_word(OP_REMOVE, 16'd10, 8'd0, 32'd0));
    send_word(make_word(OP_READ, 16'd0, 8'd2, 32'd0));
    set_config(256, 1, 1'b1);
    send_word(make_word(OP_ADD, 16'd0, 8'd0, 32'h0BAD_F00D));
    send_word(make_word(OP_ADD, 16'd1, 8'd0, 32'h1));
    send_word(make_word(OP_LOOKUP, 16'd0, 8'd0, 32'd0));
    set_config(256, 2047, 1'b1);                                     // acts as 1024
    send_word(make_word(OP_ADD, 16'd1023, 8'd0, 32'h3FF));
    send_word(make_word(OP_ADD, 16'd1024, 8'd0, 32'h400));
    send_word(make_word(OP_ADD, 16'd2047, 8'd0, 32'h7FF));
    // five live entries, now squeeze both limits under them
    set_config(2, 11, 1'b1);
    send_word(make_word(OP_ADD, 16'd5, 8'd0, 32'h5));
    send_word(make_word(OP_LOOKUP, 16'd12, 8'd0, 32'd0));
    send_word(make_word(OP_REMOVE, 16'd10, 8'd0, 32'd0));
    send_word(make_word(OP_LOOKUP, 16'd0, 8'd0, 32'd0));
    send_word(make_word(OP_READ, 16'd0, 8'd3, 32'd0));
    set_config(256, 1024, 1'b1);
    send_word(make_word(OP_REMOVE, 16'd11, 8'd0, 32'd0));
    send_word(make_word(OP_REMOVE, 16'd12, 8'd0, 32'd0));
    send_word(make_word(OP_REMOVE, 16'd0, 8'd0, 32'd0));
    send_word(make_word(OP_REMOVE, 16'd1023, 8'd0, 32'd0));
    drain();
  endtask

  // Set-only mode: no word written or moved; old words show up again once re-enabled.
  task automatic test_component_off();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_config(256, 1024, 1'b0);
    for (int i = 100; i < 108; i++) send_word(make_word(OP_ADD, 16'(i), 8'd0, $urandom));
    send_word(make_word(OP_LOOKUP, 16'd103, 8'd0, 32'd0));
    send_word(make_word(OP_READ, 16'd0, 8'd5, 32'd0));
    send_word(make_word(OP_REMOVE, 16'd101, 8'd0, 32'd0));
    send_word(make_word(OP_ADD, 16'd104, 8'd0, $urandom));
    send_word(make_word(OP_READ, 16'd0, 8'd1, 32'd0));
    set_config(256, 1024, 1'b1);
    for (int i = 0; i < 7; i++) send_word(make_word(OP_READ, 16'd0, 8'(i), 32'd0));
    send_word(make_word(OP_LOOKUP, 16'd107, 8'd0, 32'd0));
    for (int i = 100; i < 108; i++) send_word(make_word(OP_REMOVE, 16'(i), 8'd0, 32'd0));
    drain();
  endtask

  task automatic test_random_phase(input int unsigned idle_s, input int unsigned idle_r,
                                   input int n);
    int unsigned cap;
    int unsigned lim;
    case ($urandom_range(3))
      0: cap = 256;
      1: cap = 511;
      2: cap = 24;
      default: cap = 3;
    endcase
    case ($urandom_range(3))
      0: lim = 1024;
      1: lim = 2047;
      2: lim = 64;
      default: lim = 300;
    endcase
    set_config(cap, lim, 1'($urandom_range(1)));
    pick_hot_ids();
    send_idle_pct  = idle_s;
    recv_stall_pct = idle_r;
    for (int i = 0; i < n; i++) send_word(random_word());
    drain();
  endtask

  // Receiver holds off for a long stretch while words keep coming, so the input stalls.
  task automatic test_output_stall();
    set_config(256, 1024, 1'b1);
    pick_hot_ids();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 300;
    for (int i = 0; i < 40; i++) send_word(random_word());
    drain();
  endtask

  // Receiver side: random stalls, or a counted hold-off.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: each accepted word against the oldest expectation.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: status %0d slot %0d entity %0d data %h count %0d",
                   out_word.status, out_word.dense_slot, out_word.entity_out,
                   out_word.data_out, out_word.live_count);
      end else begin
        want = pending_results.pop_front();
        if (out_word.status !== want.status || out_word.dense_slot !== want.dense_slot ||
            out_word.entity_out !== want.entity_out || out_word.data_out !== want.data_out ||
            out_word.live_count !== want.live_count) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected st %0d slot %0d ent %0d data %h cnt %0d",
                     want.status, want.dense_slot, want.entity_out, want.data_out,
                     want.live_count);
            $display("          got      st %0d slot %0d ent %0d data %h cnt %0d",
                     out_word.status, out_word.dense_slot, out_word.entity_out,
                     out_word.data_out, out_word.live_count);
          end
        end
      end
    end
  end

  initial begin
    in_valid  = 1'b0;
    in_word   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_CAPACITY;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    for (int i = 0; i < MAX_ENTITIES; i++) id_order[i] = i;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // the clearing pass after reset keeps in_ready low; send_word simply waits it out
    test_directed();
    test_fill_and_empty();
    test_limits();
    test_component_off();
    test_random_phase(0, 0, 25);
    test_random_phase(86, 0, 25);
    test_random_phase(0, 86, 25);
    test_random_phase(15, 15, 25);
    test_output_stall();
    repeat (10) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("Some tests failed");
    $finish;
  end

endmodule
